// ===== design/gbr_pkg.sv =====
package gbr_pkg;

  localparam int PIX_W              = 8;
  localparam int NUM_COLOR_FIELDS   = 3;
  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_CHANNELS   = 3;

  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = 16;
  localparam int CFG_WIDTH_BITS     = 12;
  localparam int CFG_HEIGHT_BITS    = 16;
  localparam int ROW_W              = CFG_HEIGHT_BITS + 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [CFG_WIDTH_BITS-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [CFG_HEIGHT_BITS-1:0] RESET_HEIGHT = 16'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Per-item control, decided from the raster position when the item enters.
  typedef struct packed {
    logic emit;         // the item produces an output pixel
    logic row_end;      // output is the last pixel of its row
    logic frame_end;    // output is the last pixel of the frame
    logic top_zero;     // row above the output lies outside the frame
    logic bottom_zero;  // row below the output lies outside the frame
    logic left_zero;    // column left of the output lies outside the frame
    logic right_zero;   // column right of the output lies outside the frame
    logic past_frame;   // item lies below the last row, its samples count as zero
  } tap_ctl_t;

endpackage

// ===== design/gbr_ram.sv =====
module gbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/gbr_pos.sv =====
module gbr_pos
  import gbr_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         advance,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output tap_ctl_t                     ctl
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_BITS) ?
                      $clog2(MAX_WIDTH + 1) : CFG_WIDTH_BITS;

  logic [CFG_WIDTH_BITS-1:0]  width_reg;
  logic [CFG_HEIGHT_BITS-1:0] height_reg;
  logic [ROW_W-1:0]           row;
  logic [EW-1:0]              width_ext;
  logic [CW-1:0]              width_m1;
  logic [CFG_HEIGHT_BITS-1:0] height_m1;
  logic [ROW_W-1:0]           height_m1_ext;
  logic [ROW_W-1:0]           out_row;
  logic                       col_zero;
  logic                       eol;
  logic                       norm;
  logic                       cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Width zero acts as one, widths beyond the line store act as its depth.
  assign width_ext = EW'(width_reg);
  always_comb begin
    if (width_reg == '0) begin
      width_m1 = '0;
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      width_m1 = CW'(width_ext - EW'(1));
    end
  end

  assign height_m1     = (height_reg == '0) ? '0 : height_reg - 1'b1;
  assign height_m1_ext = {1'b0, height_m1};

  // At the start of a row the item closes the last pixel of the row two above;
  // elsewhere it completes the pixel one up and one left.
  assign col_zero = (col == '0);
  assign eol      = col_zero && (row >= ROW_W'(2));
  assign norm     = !col_zero && (row != '0);
  assign out_row  = eol ? row - ROW_W'(2) : row - ROW_W'(1);

  always_comb begin
    ctl.emit        = eol || norm;
    ctl.row_end     = eol;
    ctl.top_zero    = (out_row == '0);
    ctl.bottom_zero = (out_row >= height_m1_ext);
    ctl.frame_end   = eol && (out_row >= height_m1_ext);
    ctl.left_zero   = eol ? (width_m1 == '0) : (col == CW'(1));
    ctl.right_zero  = eol;
    ctl.past_frame  = (row > height_m1_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= RESET_WIDTH;
      height_reg <= RESET_HEIGHT;
      col        <= '0;
      row        <= '0;
    end else if (cfg_write) begin
      // Any register write restarts the frame; line stores and window are kept.
      if (cfg_index == CFG_IDX_WIDTH) begin
        width_reg <= cfg_data[CFG_WIDTH_BITS-1:0];
        col       <= '0;
        row       <= '0;
      end else if (cfg_index == CFG_IDX_HEIGHT) begin
        height_reg <= cfg_data[CFG_HEIGHT_BITS-1:0];
        col        <= '0;
        row        <= '0;
      end
    end else if (advance) begin
      if (ctl.emit && ctl.frame_end) begin
        col <= '0;
        row <= '0;
      end else if (col == width_m1) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

// ===== design/gbr_conv.sv =====
module gbr_conv
  import gbr_pkg::*;
(
  input  logic [2:0][2:0][PIX_W-1:0] taps,   // [row][column], row 0 on top, column 0 left
  input  tap_ctl_t                   ctl,
  output logic [PIX_W-1:0]           result
);

  localparam int HW = PIX_W + 2;
  localparam int SW = PIX_W + 4;

  logic [2:0][HW-1:0] row_sum;
  logic [SW-1:0]      total;

  // Kernel 1 2 1 separates into a horizontal and a vertical pass.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = (ctl.left_zero ? HW'(0) : HW'(taps[r][0]))
                 + (HW'(taps[r][1]) << 1)
                 + (ctl.right_zero ? HW'(0) : HW'(taps[r][2]));
    end
    total = (ctl.top_zero ? SW'(0) : SW'(row_sum[0]))
          + (SW'(row_sum[1]) << 1)
          + (ctl.bottom_zero ? SW'(0) : SW'(row_sum[2]));
  end

  assign result = total[SW-1:4];

endmodule

// ===== design/gaussian_blur_3x3_rgb.sv =====
// Streaming 3x3 Gaussian blur (kernel 1 2 1 / 2 4 2 / 1 2 1, sum >> 4) on RGB pixels sent in
// raster order, one pixel per clock sustained with no stall of its own. Pixels outside the
// frame count as zero. Results lag the input by image_width + 1 transactions: after the last
// pixel of a frame, send image_width + 1 flush transactions (tuser = 1) to drain it. A result
// leaves the output register after its transaction passes the stage-1 register. Both line buffers
// share one simple dual-port RAM of MAX_WIDTH words; a transaction reads its column when accepted,
// writes it back on leaving stage 1, and a bypass covers back-to-back accesses to one column.
// Writing a configuration register restarts the frame; write only while the block is idle.
// m_tlast marks the last pixel of a row, m_tuser the last pixel of the frame.
module gaussian_blur_3x3_rgb
  import gbr_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
  parameter int CHANNELS  = DEFAULT_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [NUM_COLOR_FIELDS*PIX_W-1:0] s_tdata,  // in_red, in_green, in_blue
  input  logic                         s_tuser,   // command
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [NUM_COLOR_FIELDS*PIX_W-1:0] m_tdata,  // out_red, out_green, out_blue
  output logic                         m_tlast,   // row_end
  output logic                         m_tuser,   // frame_end
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = CHANNELS * PIX_W;
  localparam int OW = NUM_COLOR_FIELDS * PIX_W;

  logic                 accept;
  logic [CW-1:0]        col;
  tap_ctl_t             ctl;
  logic [PW-1:0]        sample_in;

  logic                 s1_valid;
  logic                 s1_advance;
  logic [CW-1:0]        s1_addr;
  logic [PW-1:0]        s1_sample;
  tap_ctl_t             s1_ctl;

  logic [2*PW-1:0]      ram_rdata;
  logic [2*PW-1:0]      ram_wdata;
  logic                 ram_we;
  logic                 fwd;
  logic [2*PW-1:0]      fwd_data;
  logic [2*PW-1:0]      line_word;
  logic [PW-1:0]        upper_px;
  logic [PW-1:0]        middle_px;

  logic [2:0][PW-1:0]   col_a;    // older window column
  logic [2:0][PW-1:0]   col_b;    // newer window column
  logic [2:0][PW-1:0]   col_new;
  logic [OW-1:0]        result;

  assign accept = s_tvalid && s_tready;

  gbr_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .col       (col),
    .ctl       (ctl)
  );

  // Flush ticks and rows below the frame feed zero samples.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_sample
    if (c < NUM_COLOR_FIELDS) begin : g_field
      assign sample_in[c*PIX_W +: PIX_W] =
        (s_tuser == CMD_FLUSH || ctl.past_frame) ? '0 : s_tdata[c*PIX_W +: PIX_W];
    end else begin : g_none
      assign sample_in[c*PIX_W +: PIX_W] = '0;
    end
  end

  // Stage 1 moves on unless it holds a result and the output register is full with m_tready low.
  assign s1_advance = s1_valid && (!s1_ctl.emit || !m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_addr   <= col;
      s1_sample <= sample_in;
      s1_ctl    <= ctl;
    end
  end

  // Word layout: upper line in the high half, middle line in the low half.
  assign ram_we    = s1_advance;
  assign ram_wdata = {middle_px, s1_sample};

  gbr_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // A read issued on the same edge as the write-back of that column gets the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (accept) begin
      fwd <= ram_we && (col == s1_addr);
    end
    if (accept) begin
      fwd_data <= ram_wdata;
    end
  end

  assign line_word = fwd ? fwd_data : ram_rdata;
  assign upper_px  = line_word[2*PW-1:PW];
  assign middle_px = line_word[PW-1:0];

  always_comb begin
    col_new[0] = upper_px;
    col_new[1] = middle_px;
    col_new[2] = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_a <= '0;
      col_b <= '0;
    end else if (s1_advance) begin
      col_a <= col_b;
      col_b <= col_new;
    end
  end

  for (genvar c = 0; c < NUM_COLOR_FIELDS; c++) begin : g_out
    if (c < CHANNELS) begin : g_conv
      logic [2:0][2:0][PIX_W-1:0] taps;
      always_comb begin
        for (int r = 0; r < 3; r++) begin
          taps[r][0] = col_a[r][c*PIX_W +: PIX_W];
          taps[r][1] = col_b[r][c*PIX_W +: PIX_W];
          taps[r][2] = col_new[r][c*PIX_W +: PIX_W];
        end
      end
      gbr_conv u_conv (
        .taps   (taps),
        .ctl    (s1_ctl),
        .result (result[c*PIX_W +: PIX_W])
      );
    end else begin : g_blank
      assign result[c*PIX_W +: PIX_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance && s1_ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_advance && s1_ctl.emit) begin
      m_tdata <= result;
      m_tlast <= s1_ctl.row_end;
      m_tuser <= s1_ctl.frame_end;
    end
  end

endmodule
